### design/chaotic_pixel_permuter_unit_defines.svh
// ----------------------------------------------------------------------------
// Chaotic pixel permuter assertion macros
// Shared concurrent assertion forms for the permuter modules.
// ----------------------------------------------------------------------------
`ifndef CHAOTIC_PIXEL_PERMUTER_UNIT_DEFINES_SVH
`define CHAOTIC_PIXEL_PERMUTER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CPP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that must hold whenever its trigger holds.
`define CPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/cpp_pkg.sv
// ----------------------------------------------------------------------------
// Chaotic pixel permuter package
// Constants, codes and shared types of the pixel permuter.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Default frame capacity and register defaults.
  localparam int MAX_PIXELS_DEF = 65536;
  localparam int MIN_PIXELS     = 2;
  localparam int COUNT_W        = 17;
  localparam int SEED_W         = 32;
  localparam logic [COUNT_W-1:0] COUNT_RST = 17'd65536;
  localparam logic [SEED_W-1:0]  SEED_RST  = 32'd1288490189;

  // Configuration port.
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHAOS_SEED  = 2'd2;

  // Item kinds.
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Direction codes.
  localparam logic DIR_SCRAMBLE   = 1'b0;
  localparam logic DIR_UNSCRAMBLE = 1'b1;

  // Result queue sizing.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic   last;
    logic   err;
    pixel_t pix;
  } out_item_t;

endpackage

### design/cpp_perm_build.sv
// ----------------------------------------------------------------------------
// Permutation builder
// Holds the permutation memory, fills it with identity on start and then
// swaps entry i with entry j = floor(x * N) for every i, with x = frac(1.5x).
// ----------------------------------------------------------------------------
`include "chaotic_pixel_permuter_unit_defines.svh"

module cpp_perm_build #(
  parameter  int MAX_PIXELS = cpp_pkg::MAX_PIXELS_DEF,
  localparam int IDX_W      = $clog2(MAX_PIXELS),
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [cpp_pkg::SEED_W-1:0] seed_i,
  input  logic [CNT_W-1:0]          size_i,
  input  logic                      lk_en_i,
  input  logic [IDX_W-1:0]          lk_addr_i,
  output logic [IDX_W-1:0]          lk_data_o,
  output logic                      busy_o
);

  localparam int PROD_W = cpp_pkg::SEED_W + CNT_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_FILL = 3'd1;
  localparam logic [2:0] B_CALC = 3'd2;
  localparam logic [2:0] B_MULT = 3'd3;
  localparam logic [2:0] B_READ = 3'd4;
  localparam logic [2:0] B_WR_I = 3'd5;
  localparam logic [2:0] B_WR_J = 3'd6;

  logic [2:0]                  st_r, st_nxt;
  logic [IDX_W-1:0]            i_r;
  logic [IDX_W-1:0]            j_r;
  logic [cpp_pkg::SEED_W-1:0]  x_r;
  logic [IDX_W-1:0]            rda_r;
  logic [IDX_W-1:0]            rdb_r;
  logic [IDX_W-1:0]            perm_mem [MAX_PIXELS];

  logic                        i_last;
  logic [cpp_pkg::SEED_W+1:0]  x3;
  logic [PROD_W-1:0]           prod;
  logic                        we;
  logic [IDX_W-1:0]            waddr;
  logic [IDX_W-1:0]            wdata;
  logic                        rda_en;
  logic [IDX_W-1:0]            rda_addr;

  // Loop bound and map arithmetic.
  assign i_last = (CNT_W'(i_r) == (size_i - CNT_W'(1)));
  assign x3     = {2'b00, x_r} + {1'b0, x_r, 1'b0};
  assign prod   = PROD_W'(x_r) * PROD_W'(size_i);

  // Sequencer: next state and memory write port.
  always_comb begin
    st_nxt = st_r;
    we     = 1'b0;
    waddr  = i_r;
    wdata  = i_r;
    unique case (st_r)
      B_IDLE: begin
        if (start_i) st_nxt = B_FILL;
      end
      B_FILL: begin
        we = 1'b1;
        if (i_last) st_nxt = B_CALC;
      end
      B_CALC: st_nxt = B_MULT;
      B_MULT: st_nxt = B_READ;
      B_READ: st_nxt = B_WR_I;
      B_WR_I: begin
        we     = 1'b1;
        wdata  = rdb_r;
        st_nxt = B_WR_J;
      end
      B_WR_J: begin
        we     = 1'b1;
        waddr  = j_r;
        wdata  = rda_r;
        st_nxt = i_last ? B_IDLE : B_CALC;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Port A serves lookups while idle and entry i during a swap.
  assign rda_en   = (st_r == B_READ) || lk_en_i;
  assign rda_addr = (st_r == B_IDLE) ? lk_addr_i : i_r;

  // State and loop registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      i_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_IDLE && start_i) begin
        i_r <= '0;
      end else if (st_r == B_FILL) begin
        i_r <= i_last ? '0 : i_r + IDX_W'(1);
      end else if (st_r == B_WR_J) begin
        i_r <= i_r + IDX_W'(1);
      end
    end
  end

  // Map value and swap partner.
  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && start_i) x_r <= seed_i;
    else if (st_r == B_CALC) x_r <= x3[cpp_pkg::SEED_W:1];
    if (st_r == B_MULT) j_r <= prod[cpp_pkg::SEED_W +: IDX_W];
  end

  // Permutation memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) perm_mem[waddr] <= wdata;
    if (rda_en) rda_r <= perm_mem[rda_addr];
    if (st_r == B_READ) rdb_r <= perm_mem[j_r];
  end

  assign lk_data_o = rda_r;
  assign busy_o    = (st_r != B_IDLE);

  `CPP_ASSERT_IMPLY(a_swap_in_range, clk, rst_n, st_r == B_READ,
    CNT_W'(j_r) < size_i, "swap partner outside the frame")
  `CPP_ASSERT_IMPLY(a_no_start_busy, clk, rst_n, st_r != B_IDLE,
    !start_i, "start seen while the permutation is being built")

endmodule

### design/cpp_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue between the read pipeline and the result channel.
// ----------------------------------------------------------------------------
`include "chaotic_pixel_permuter_unit_defines.svh"

module cpp_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_i,
  input  cpp_pkg::out_item_t        item_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output cpp_pkg::out_item_t        item_o
);

  cpp_pkg::out_item_t                  q_r [cpp_pkg::OUT_DEPTH];
  logic [cpp_pkg::OUT_PTR_W-1:0]       wr_ptr_r;
  logic [cpp_pkg::OUT_PTR_W-1:0]       rd_ptr_r;
  logic [cpp_pkg::OUT_CNT_W-1:0]       cnt_r;
  logic                                pop;

  assign pop = pop_i && (cnt_r != '0);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + cpp_pkg::OUT_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + cpp_pkg::OUT_PTR_W'(1);
      unique case ({push_i, pop})
        2'b10:   cnt_r <= cnt_r + cpp_pkg::OUT_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - cpp_pkg::OUT_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_i) q_r[wr_ptr_r] <= item_i;
  end

  assign valid_o = (cnt_r != '0);
  assign item_o  = q_r[rd_ptr_r];

  `CPP_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push_i && !pop,
    cnt_r < cpp_pkg::OUT_CNT_W'(cpp_pkg::OUT_DEPTH), "result queue overflow")

endmodule

### design/chaotic_pixel_permuter_unit.sv
// ----------------------------------------------------------------------------
// Chaotic pixel permuter
// Scrambles or unscrambles a frame of 3-byte pixels with a keyed permutation.
//
//   Channel  Direction  Contents
//   in_      slave      tuser: kind; tdata: blue, green, red
//   out_     master     tdata: blue, green, red; tlast: last pixel; tuser: error
//   cfg_     write      index 0 direction, 1 pixel count, 2 chaos seed
//
// A start item fills the permutation with identity, then runs a swap step per pixel
// (map update, index multiply, paired read, two writes through the one write port).
// Loads and reads are pipelined; a read's result is registered in stages B and C
// and then queued. Reset is synchronous and clears only control state; both memories
// hold garbage until written, with no clearing pass. The input stalls while the
// permutation is built or while four results are in flight or wait for transfer.
// ----------------------------------------------------------------------------
`include "chaotic_pixel_permuter_unit_defines.svh"

module chaotic_pixel_permuter_unit #(
  parameter  int MAX_PIXELS = cpp_pkg::MAX_PIXELS_DEF,
  localparam int IDX_W      = $clog2(MAX_PIXELS),
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // blue_in, green_in, red_in
  input  logic [cpp_pkg::KIND_W-1:0]    in_tuser,   // kind
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // blue_out, green_out, red_out
  output logic                          out_tlast,  // last_pixel
  output logic                          out_tuser,  // status
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [cpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cpp_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic                           dir_cfg_r;
  logic [cpp_pkg::COUNT_W-1:0]    count_cfg_r;
  logic [cpp_pkg::SEED_W-1:0]     seed_cfg_r;

  // Frame state.
  logic                           frame_dir_r;
  logic [CNT_W-1:0]               frame_r;
  logic [CNT_W-1:0]               loaded_r;
  logic [CNT_W-1:0]               emitted_r;
  logic [cpp_pkg::OUT_CNT_W-1:0]  cr_r, cr_nxt;

  // Stage B: permutation data available.
  logic                           b_valid_r;
  logic                           b_load_r;
  logic                           b_err_r;
  logic                           b_last_r;
  logic                           b_dir_r;
  logic [IDX_W-1:0]               b_cnt_r;
  cpp_pkg::pixel_t                b_pix_r;

  // Stage C: pixel data available.
  logic                           c_valid_r;
  logic                           c_err_r;
  logic                           c_last_r;
  cpp_pkg::pixel_t                st_rd_r;
  cpp_pkg::pixel_t                store_mem [MAX_PIXELS];

  logic                           in_acc;
  logic                           a_start;
  logic                           a_load;
  logic                           a_read;
  logic                           a_err;
  logic                           a_last;
  logic [31:0]                    cnt32;
  logic [31:0]                    size_clamp;
  logic [IDX_W-1:0]               lk_addr;
  logic [IDX_W-1:0]               perm_rd;
  logic                           bld_busy;
  logic                           st_we;
  logic [IDX_W-1:0]               st_waddr;
  logic                           st_re;
  logic [IDX_W-1:0]               st_raddr;
  logic                           pop;
  cpp_pkg::out_item_t             push_item;
  cpp_pkg::out_item_t             head;

  // Configuration writes; unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_cfg_r   <= cpp_pkg::DIR_SCRAMBLE;
      count_cfg_r <= cpp_pkg::COUNT_RST;
      seed_cfg_r  <= cpp_pkg::SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cpp_pkg::CFG_DIRECTION:   dir_cfg_r   <= cfg_wdata[0];
        cpp_pkg::CFG_PIXEL_COUNT: count_cfg_r <= cfg_wdata[cpp_pkg::COUNT_W-1:0];
        cpp_pkg::CFG_CHAOS_SEED:  seed_cfg_r  <= cfg_wdata[cpp_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Item decode at the input transfer.
  assign in_tready = !bld_busy && (cr_r < cpp_pkg::OUT_CNT_W'(cpp_pkg::OUT_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign a_start   = in_acc && (in_tuser == cpp_pkg::KIND_START);
  assign a_load    = in_acc && (in_tuser == cpp_pkg::KIND_LOAD) && (loaded_r < frame_r);
  assign a_read    = in_acc && (in_tuser == cpp_pkg::KIND_READ);
  assign a_err     = (loaded_r < frame_r) || (emitted_r >= frame_r);
  assign a_last    = ((emitted_r + CNT_W'(1)) == frame_r);
  assign lk_addr   = (in_tuser == cpp_pkg::KIND_LOAD) ? loaded_r[IDX_W-1:0]
                                                       : emitted_r[IDX_W-1:0];

  // Frame size saturated into the supported range.
  assign cnt32      = 32'(count_cfg_r);
  assign size_clamp = (cnt32 < 32'(cpp_pkg::MIN_PIXELS)) ? 32'(cpp_pkg::MIN_PIXELS) :
                      (cnt32 > 32'(MAX_PIXELS))          ? 32'(MAX_PIXELS) : cnt32;

  // Frame counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_dir_r <= cpp_pkg::DIR_SCRAMBLE;
      frame_r     <= '0;
      loaded_r    <= '0;
      emitted_r   <= '0;
    end else if (a_start) begin
      frame_dir_r <= dir_cfg_r;
      frame_r     <= CNT_W'(size_clamp);
      loaded_r    <= '0;
      emitted_r   <= '0;
    end else begin
      if (a_load) loaded_r <= loaded_r + CNT_W'(1);
      if (a_read && !a_err) emitted_r <= emitted_r + CNT_W'(1);
    end
  end

  // Permutation builder and lookup.
  cpp_perm_build #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (a_start),
    .seed_i    (seed_cfg_r),
    .size_i    (frame_r),
    .lk_en_i   (a_load || a_read),
    .lk_addr_i (lk_addr),
    .lk_data_o (perm_rd),
    .busy_o    (bld_busy)
  );

  // Stage B registers.
  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else b_valid_r <= a_load || a_read;
    b_load_r <= a_load;
    b_err_r  <= a_err;
    b_last_r <= a_last;
    b_dir_r  <= frame_dir_r;
    b_cnt_r  <= lk_addr;
    b_pix_r  <= cpp_pkg::pixel_t'(in_tdata);
  end

  // Pixel store addressing: scramble writes through the permutation,
  // unscramble reads through it.
  assign st_we    = b_valid_r && b_load_r;
  assign st_waddr = (b_dir_r == cpp_pkg::DIR_SCRAMBLE) ? perm_rd : b_cnt_r;
  assign st_re    = b_valid_r && !b_load_r && !b_err_r;
  assign st_raddr = (b_dir_r == cpp_pkg::DIR_SCRAMBLE) ? b_cnt_r : perm_rd;

  // Pixel store memory.
  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= b_pix_r;
    if (st_re) st_rd_r <= store_mem[st_raddr];
  end

  // Stage C registers.
  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else c_valid_r <= b_valid_r && !b_load_r;
    c_err_r  <= b_err_r;
    c_last_r <= b_last_r && !b_err_r;
  end

  assign push_item.last = c_last_r;
  assign push_item.err  = c_err_r;
  assign push_item.pix  = c_err_r ? '0 : st_rd_r;

  // Result queue and output transfer.
  cpp_out_fifo u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (c_valid_r),
    .item_i  (push_item),
    .pop_i   (out_tready),
    .valid_o (out_tvalid),
    .item_o  (head)
  );

  assign out_tdata = head.pix;
  assign out_tlast = head.last;
  assign out_tuser = head.err;
  assign pop       = out_tvalid && out_tready;

  // Reads in flight or queued, bounded by the queue depth.
  always_comb begin
    unique case ({a_read, pop})
      2'b10:   cr_nxt = cr_r + cpp_pkg::OUT_CNT_W'(1);
      2'b01:   cr_nxt = cr_r - cpp_pkg::OUT_CNT_W'(1);
      default: cr_nxt = cr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cr_r <= '0;
    else cr_r <= cr_nxt;
  end

  `CPP_ASSERT_ALWAYS(a_credit_bound, clk, rst_n,
    cr_r <= cpp_pkg::OUT_CNT_W'(cpp_pkg::OUT_DEPTH), "result credit over queue depth")
  `CPP_ASSERT_ALWAYS(a_load_bound, clk, rst_n,
    loaded_r <= frame_r, "more loads taken than the frame holds")
  `CPP_ASSERT_ALWAYS(a_emit_bound, clk, rst_n,
    emitted_r <= loaded_r, "pixel emitted before being loaded")

endmodule

### tb/sv/tb_chaotic_pixel_permuter_unit.sv
// ----------------------------------------------------------------------------
// Chaotic pixel permuter testbench
// Drives start, load and read transfers into the permuter and checks every
// pixel it returns against a cycle-free model of the keyed shuffle. A short
// list of hand-picked transfers comes first, then random frames of varied
// size, direction and seed with random gaps on both streams, a long stall of
// the result stream, and malformed frames mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chaotic_pixel_permuter_unit;
  import cpp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam out_item_t READ_ERROR = {1'b0, 1'b1, 24'h000000};

  // Hand-picked part: transfers and register writes, in order.
  typedef enum logic [1:0] {ROW_SEND, ROW_SEND_ERR, ROW_WRITE} row_op_t;
  typedef struct packed {
    row_op_t     op;
    logic [1:0]  code;   // item kind, or register index for a write
    logic [31:0] value;  // packed pixel, or register data
  } plan_row_t;

  localparam int PLAN_LEN = 32;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Nothing started since reset.
    '{ROW_SEND_ERR, KIND_READ,       32'h0},
    '{ROW_SEND,     KIND_LOAD,       32'hFFFFFF},
    '{ROW_SEND,     KIND_UNUSED,     32'h0},
    // Size below the minimum saturates to two pixels; seed of zero.
    '{ROW_WRITE,    CFG_PIXEL_COUNT, 32'd1},
    '{ROW_WRITE,    CFG_CHAOS_SEED,  32'd0},
    '{ROW_WRITE,    CFG_DIRECTION,   {31'd0, DIR_SCRAMBLE}},
    '{ROW_SEND,     KIND_START,      32'h0},
    '{ROW_SEND_ERR, KIND_READ,       32'h0},
    '{ROW_SEND,     KIND_LOAD,       32'h000000},
    '{ROW_SEND,     KIND_LOAD,       32'hFFFFFF},
    '{ROW_SEND,     KIND_LOAD,       32'hC35AA5},
    '{ROW_SEND,     KIND_READ,       32'h0},
    '{ROW_SEND,     KIND_READ,       32'h0},
    '{ROW_SEND_ERR, KIND_READ,       32'h0},
    // Unscramble a three-pixel frame; the direction change mid-frame is held off.
    '{ROW_WRITE,    CFG_DIRECTION,   {31'd0, DIR_UNSCRAMBLE}},
    '{ROW_WRITE,    CFG_CHAOS_SEED,  32'hFFFFFFFF},
    '{ROW_WRITE,    CFG_PIXEL_COUNT, 32'd3},
    '{ROW_SEND,     KIND_START,      32'h0},
    '{ROW_SEND,     KIND_LOAD,       32'h563412},
    '{ROW_WRITE,    CFG_DIRECTION,   {31'd0, DIR_SCRAMBLE}},
    '{ROW_SEND,     KIND_LOAD,       32'h0F0F0F},
    '{ROW_SEND,     KIND_LOAD,       32'hF0F0F0},
    '{ROW_SEND,     KIND_READ,       32'h0},
    '{ROW_SEND,     KIND_READ,       32'h0},
    '{ROW_SEND,     KIND_READ,       32'h0},
    // Size above capacity saturates to the full frame, left unfinished.
    '{ROW_WRITE,    CFG_PIXEL_COUNT, 32'h1FFFF},
    '{ROW_WRITE,    CFG_CHAOS_SEED,  32'h80000001},
    '{ROW_SEND,     KIND_START,      32'h0},
    '{ROW_SEND,     KIND_LOAD,       32'h010203},
    '{ROW_SEND,     KIND_LOAD,       32'hFEFDFC},
    '{ROW_SEND_ERR, KIND_READ,       32'h0},
    '{ROW_SEND,     KIND_UNUSED,     32'hFFFFFF}
  };

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  chaotic_pixel_permuter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Model state: registers, latched frame and both memories.
  logic                cfg_dir_q   = DIR_SCRAMBLE;
  logic [COUNT_W-1:0]  cfg_count_q = COUNT_RST;
  logic [SEED_W-1:0]   cfg_seed_q  = SEED_RST;
  int                  frame_n     = 0;
  logic                frame_dir   = DIR_SCRAMBLE;
  int                  loaded_n    = 0;
  int                  emitted_n   = 0;
  logic [15:0]         shuffle_tbl [MAX_PIXELS_DEF];
  logic [23:0]         frame_mem   [MAX_PIXELS_DEF];

  out_item_t pending_pixels[$];
  int        effective_cnt = 0;
  int        bad_cnt       = 0;
  int        gap_next      = 1;
  int        settle_cycles = SETTLE_CYCLES;
  bit        no_idle       = 1'b0;
  bit        hold_req      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("chaotic_pixel_permuter_unit test failed");
    $finish;
  end

  function automatic int clamp_count(input logic [COUNT_W-1:0] c);
    if (c < COUNT_W'(MIN_PIXELS)) return MIN_PIXELS;
    if (c > COUNT_W'(MAX_PIXELS_DEF)) return MAX_PIXELS_DEF;
    return int'(c);
  endfunction

  // Latch the frame and walk the map x = frac(1.5x), swapping i with floor(x*N).
  function automatic void build_shuffle();
    logic [63:0] tripled;
    logic [63:0] scaled;
    logic [31:0] x;
    logic [15:0] t;
    int          i;
    int          j;
    frame_n   = clamp_count(cfg_count_q);
    frame_dir = cfg_dir_q;
    loaded_n  = 0;
    emitted_n = 0;
    for (i = 0; i < frame_n; i++) shuffle_tbl[i] = i[15:0];
    x = cfg_seed_q;
    for (i = 0; i < frame_n; i++) begin
      tripled = {32'd0, x} * 64'd3;
      x       = tripled[32:1];
      scaled  = {32'd0, x} * 64'(frame_n);
      j       = int'(scaled[63:32]);
      t              = shuffle_tbl[i];
      shuffle_tbl[i] = shuffle_tbl[j];
      shuffle_tbl[j] = t;
    end
  endfunction

  // Apply one accepted transfer to the model; returns 1 when a pixel is due.
  function automatic bit permute_step(input logic [KIND_W-1:0] kind, input logic [23:0] pix,
                                      output out_item_t res);
    int pos;
    res = READ_ERROR;
    case (kind)
      KIND_START: begin
        build_shuffle();
        effective_cnt++;
        return 1'b0;
      end
      KIND_LOAD: begin
        if (loaded_n >= frame_n) return 1'b0;
        pos = (frame_dir == DIR_SCRAMBLE) ? int'(shuffle_tbl[loaded_n]) : loaded_n;
        frame_mem[pos] = pix;
        loaded_n++;
        effective_cnt++;
        return 1'b0;
      end
      KIND_READ: begin
        effective_cnt++;
        if (loaded_n < frame_n || emitted_n >= frame_n) return 1'b1;
        pos = (frame_dir == DIR_SCRAMBLE) ? emitted_n : int'(shuffle_tbl[emitted_n]);
        res.pix  = frame_mem[pos];
        res.last = (emitted_n + 1 == frame_n);
        res.err  = 1'b0;
        emitted_n++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // One input transfer. Valid stays high into the next item only when its gap is zero.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [23:0] pix,
                           input bit typed_err);
    out_item_t res;
    if (gap_next > 0) repeat (gap_next) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pix;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    if (permute_step(kind, pix, res)) pending_pixels.push_back(typed_err ? READ_ERROR : res);
    // A start keeps the block busy for the shuffle build even with nothing due.
    settle_cycles = (kind == KIND_START) ? 6 * frame_n + SETTLE_CYCLES : SETTLE_CYCLES;
    gap_next = no_idle ? 0 : $urandom_range(0, 4);
    if (gap_next != 0) in_tvalid <= 1'b0;
  endtask

  // Drain every due pixel and let the block settle; called in the step of the last transfer.
  task automatic wait_idle();
    if (gap_next == 0) begin
      in_tvalid <= 1'b0;
      gap_next = 1;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
    settle_cycles = SETTLE_CYCLES;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      CFG_DIRECTION:   cfg_dir_q   = val[0];
      CFG_PIXEL_COUNT: cfg_count_q = val[COUNT_W-1:0];
      CFG_CHAOS_SEED:  cfg_seed_q  = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 15))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  // New register settings while idle; the first call fixes a mid-size frame.
  task automatic retune(input bit first);
    logic [CFG_W-1:0] val;
    wait_idle();
    if (first || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 19))
        0:       val = 32'($urandom_range(0, 1));
        1, 2:    val = 32'($urandom_range(25, 160));
        default: val = 32'($urandom_range(2, 24));
      endcase
      write_reg(CFG_PIXEL_COUNT, first ? 32'd40 : val);
    end
    if (first || $urandom_range(0, 1) == 1)
      write_reg(CFG_DIRECTION, 32'($urandom_range(0, 1)));
    if (first || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 9))
        0:       val = 32'h00000000;
        1:       val = 32'hFFFFFFFF;
        default: val = $urandom();
      endcase
      write_reg(CFG_CHAOS_SEED, val);
    end
  endtask

  // One frame: start, loads, reads, with malformed shapes and stray items mixed in.
  task automatic run_frame(input bit squeeze);
    int n;
    int loads;
    int reads;
    int i;
    n     = clamp_count(cfg_count_q);
    loads = n;
    reads = n;
    if (!squeeze) begin
      case ($urandom_range(0, 9))
        0: begin  // unfinished frame read too early
          loads = $urandom_range(0, n - 1);
          reads = $urandom_range(1, 3);
        end
        1: reads = n + $urandom_range(1, 3);   // reads past the end
        2: loads = n + $urandom_range(1, 3);   // surplus loads are dropped
        3: reads = $urandom_range(0, n - 1);   // cut short by the next start
        default: ;
      endcase
    end
    send_item(KIND_START, rand_pixel(), 1'b0);
    for (i = 0; i < loads; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item($urandom_range(0, 1) ? KIND_UNUSED : KIND_READ, rand_pixel(), 1'b0);
      send_item(KIND_LOAD, rand_pixel(), 1'b0);
    end
    // Register changes inside a frame only take effect at the next start.
    if (!squeeze && $urandom_range(0, 7) == 0) retune(1'b0);
    if (squeeze) hold_req = 1'b1;
    for (i = 0; i < reads; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item($urandom_range(0, 1) ? KIND_UNUSED : KIND_LOAD, rand_pixel(), 1'b0);
      send_item(KIND_READ, rand_pixel(), 1'b0);
    end
  endtask

  // Result side: random stalls per transfer, one long hold-off on request.
  initial begin : result_sink
    out_item_t got;
    out_item_t want;
    int        hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      got = {out_tlast, out_tuser, out_tdata};
      if (pending_pixels.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS)
          $display("unexpected pixel: b=%h g=%h r=%h last=%b err=%b",
                   got.pix.blue, got.pix.green, got.pix.red, got.last, got.err);
      end else begin
        want = pending_pixels.pop_front();
        if (got.pix.blue !== want.pix.blue || got.pix.green !== want.pix.green ||
            got.pix.red !== want.pix.red || got.last !== want.last ||
            got.err !== want.err) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORTS)
            $display({"pixel mismatch: expected b=%h g=%h r=%h last=%b err=%b, ",
                      "got b=%h g=%h r=%h last=%b err=%b"},
                     want.pix.blue, want.pix.green, want.pix.red, want.last, want.err,
                     got.pix.blue, got.pix.green, got.pix.red, got.last, got.err);
        end
      end
    end
  end

  // Stimulus: reset, hand-picked rows, random frames, then drain.
  initial begin : stimulus
    int target;
    bit first;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[r]) begin
      case (PLAN[r].op)
        ROW_WRITE: begin
          wait_idle();
          write_reg(PLAN[r].code, PLAN[r].value);
        end
        default: send_item(PLAN[r].code, PLAN[r].value[23:0], PLAN[r].op == ROW_SEND_ERR);
      endcase
    end

    target = effective_cnt + RANDOM_ITEMS;
    first  = 1'b1;
    while (effective_cnt < target) begin
      if (first || $urandom_range(0, 2) == 0) retune(first);
      no_idle = first || ($urandom_range(0, 4) == 0);
      run_frame(first);
      first = 1'b0;
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_cnt == 0)
      $display("chaotic_pixel_permuter_unit test passed");
    else
      $display("chaotic_pixel_permuter_unit test failed");
    $finish;
  end

endmodule

### chaotic_pixel_permuter_unit.f
+incdir+design
design/cpp_pkg.sv
design/cpp_perm_build.sv
design/cpp_out_fifo.sv
design/chaotic_pixel_permuter_unit.sv
tb/sv/tb_chaotic_pixel_permuter_unit.sv
